### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the stack design files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Invariant that holds at every edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

`endif

### rtl/lss_pkg.sv
// ----------------------------------------------------------------------------
// lss_pkg
// Shared constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package lss_pkg;

    localparam int DEPTH  = 128;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int WORD_W = 32;
    localparam int OP_W   = 2;
    localparam int ST_W   = 2;
    localparam int OCC_W  = 8;

    // Commands.
    localparam logic [OP_W-1:0] OP_PUSH = 2'd0;
    localparam logic [OP_W-1:0] OP_POP  = 2'd1;
    localparam logic [OP_W-1:0] OP_PEEK = 2'd2;
    localparam logic [OP_W-1:0] OP_SORT = 2'd3;

    // Result status codes.
    localparam logic [ST_W-1:0] STAT_OK    = 2'd0;
    localparam logic [ST_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [ST_W-1:0] STAT_FULL  = 2'd2;

    // Selects what the output register loads.
    localparam int OUT_SEL_W = 3;
    localparam logic [OUT_SEL_W-1:0] OUT_PUSH  = 3'd0;
    localparam logic [OUT_SEL_W-1:0] OUT_FULL  = 3'd1;
    localparam logic [OUT_SEL_W-1:0] OUT_EMPTY = 3'd2;
    localparam logic [OUT_SEL_W-1:0] OUT_READ  = 3'd3;
    localparam logic [OUT_SEL_W-1:0] OUT_SORT  = 3'd4;

    // Commands from the controller to the datapath. The scratch store is
    // read at t - 1 on every cycle.
    typedef struct packed {
        logic                 push_wr;   // write push value at the top, count up
        logic                 cnt_dec;   // count down (pop)
        logic                 rd_top;    // read element store at count - 1
        logic                 sort_init; // n <= count, t <= 0
        logic                 n_dec_rd;  // n <= n - 1, read element store at n - 1
        logic                 load_v;    // capture the element read into v
        logic                 t_dec;     // t <= t - 1
        logic                 e_wr_s;    // element store[n] <= scratch word, n <= n + 1
        logic                 s_push;    // scratch store[t] <= v, t <= t + 1
        logic                 load_out;  // load the output register
        logic [OUT_SEL_W-1:0] out_sel;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic count_zero;
        logic count_full;
        logic n_zero;
        logic t_zero;
        logic s_gt_v;
        logic out_valid;
    } t_dp_stat;

endpackage

### rtl/lifo_stack_with_sort_unit.sv
// Push, a full push and a pop or peek on an empty stack: result in the cycle after acceptance.
// Pop and peek of a stored word: result through the registered RAM read, then the output register.
// One request per cycle while the result channel does not stall; a pop or peek of a stored word
// blocks the next request until its result is loaded. Sort of N words: the K words moved back
// (at most N*(N-1)/2) are each sorted again. No request meanwhile.
// Reset (synchronous, active low) empties the stack at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
// lifo_stack_with_sort_unit
// Bounded LIFO stack of signed words with push, pop, peek and an in-place
// two-stack insertion sort.
// ----------------------------------------------------------------------------
module lifo_stack_with_sort_unit
    import lss_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // Request channel.
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [OP_W-1:0]          i_op,
    input  logic signed [WORD_W-1:0] i_push_value,
    // Result channel.
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic signed [WORD_W-1:0] o_read_value,
    output logic [ST_W-1:0]          o_status,
    output logic [OCC_W-1:0]         o_occupancy
);

    // The controller decides what happens each cycle and the datapath does
    // it. They talk only through the command and status bundles below.
    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // A request is taken only in the idle state and only when the output
    // register is empty or is being drained in the same cycle, so every
    // result always has a free place to land. Results of push and of the
    // error cases are loaded in the cycle the request is taken.
    lss_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_out_stall (i_out_stall),
        .i_op        (i_op),
        .i_stat      (dp_stat),
        .o_cmd       (dp_cmd)
    );

    // The sort pops each word off the element store, moves larger words
    // from the scratch stack back onto the element store until the word
    // fits, then pushes it onto the scratch stack. At the end the scratch
    // stack is poured back, leaving the smallest word on top.
    lss_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .o_stat       (dp_stat),
        .i_push_value (i_push_value),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_read_value (o_read_value),
        .o_status     (o_status),
        .o_occupancy  (o_occupancy)
    );

endmodule

### rtl/lss_ram.sv
// ----------------------------------------------------------------------------
// lss_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module lss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/lss_ctrl.sv
// ----------------------------------------------------------------------------
// lss_ctrl
// Command sequencer: accepts requests and steps the datapath through each one.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lss_ctrl
    import lss_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  logic            i_out_stall,
    input  logic [OP_W-1:0] i_op,
    input  t_dp_stat        i_stat,
    output t_dp_cmd         o_cmd
);

    localparam int SM_W = 4;
    localparam logic [SM_W-1:0] ST_IDLE      = 4'd0;
    localparam logic [SM_W-1:0] ST_RD_OUT    = 4'd1;
    localparam logic [SM_W-1:0] ST_SORT_LOOP = 4'd2;
    localparam logic [SM_W-1:0] ST_LOAD_V    = 4'd3;
    localparam logic [SM_W-1:0] ST_RD_TOP    = 4'd4;
    localparam logic [SM_W-1:0] ST_CMP       = 4'd5;
    localparam logic [SM_W-1:0] ST_PUSH_V    = 4'd6;
    localparam logic [SM_W-1:0] ST_FLUSH     = 4'd7;
    localparam logic [SM_W-1:0] ST_FLUSH_WR  = 4'd8;

    logic [SM_W-1:0] r_state;
    logic [SM_W-1:0] n_state;
    logic            out_free;
    logic            accept;

    // The output register can take a result when it is empty or drains now.
    assign out_free   = !i_stat.out_valid || !i_out_stall;
    assign o_in_stall = !((r_state == ST_IDLE) && out_free);
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (i_op)
                        OP_PUSH: begin
                            o_cmd.load_out = 1'b1;
                            if (i_stat.count_full) begin
                                o_cmd.out_sel = OUT_FULL;
                            end else begin
                                o_cmd.push_wr = 1'b1;
                                o_cmd.out_sel = OUT_PUSH;
                            end
                        end
                        OP_POP, OP_PEEK: begin
                            if (i_stat.count_zero) begin
                                o_cmd.load_out = 1'b1;
                                o_cmd.out_sel  = OUT_EMPTY;
                            end else begin
                                o_cmd.rd_top  = 1'b1;
                                o_cmd.cnt_dec = (i_op == OP_POP);
                                n_state       = ST_RD_OUT;
                            end
                        end
                        OP_SORT: begin
                            o_cmd.sort_init = 1'b1;
                            n_state         = ST_SORT_LOOP;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_RD_OUT: begin
                o_cmd.load_out = 1'b1;
                o_cmd.out_sel  = OUT_READ;
                n_state        = ST_IDLE;
            end
            ST_SORT_LOOP: begin
                if (i_stat.n_zero) begin
                    n_state = ST_FLUSH;
                end else begin
                    o_cmd.n_dec_rd = 1'b1;
                    n_state        = ST_LOAD_V;
                end
            end
            ST_LOAD_V: begin
                o_cmd.load_v = 1'b1;
                n_state      = ST_RD_TOP;
            end
            ST_RD_TOP: begin
                if (i_stat.t_zero) begin
                    n_state = ST_PUSH_V;
                end else begin
                    n_state = ST_CMP;
                end
            end
            ST_CMP: begin
                if (i_stat.s_gt_v) begin
                    o_cmd.t_dec  = 1'b1;
                    o_cmd.e_wr_s = 1'b1;
                    n_state      = ST_RD_TOP;
                end else begin
                    n_state = ST_PUSH_V;
                end
            end
            ST_PUSH_V: begin
                o_cmd.s_push = 1'b1;
                n_state      = ST_SORT_LOOP;
            end
            ST_FLUSH: begin
                if (i_stat.t_zero) begin
                    o_cmd.load_out = 1'b1;
                    o_cmd.out_sel  = OUT_SORT;
                    n_state        = ST_IDLE;
                end else begin
                    o_cmd.t_dec = 1'b1;
                    n_state     = ST_FLUSH_WR;
                end
            end
            ST_FLUSH_WR: begin
                o_cmd.e_wr_s = 1'b1;
                n_state      = ST_FLUSH;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `ASSERT_IMPL(a_busy_stalls, i_clk, i_rst_n, r_state != ST_IDLE, o_in_stall,
                 "request taken while busy")
    `ASSERT_NEXT(a_sort_starts, i_clk, i_rst_n, accept && (i_op == OP_SORT),
                 r_state == ST_SORT_LOOP, "sort did not start")

endmodule

### rtl/lss_dp.sv
// ----------------------------------------------------------------------------
// lss_dp
// Datapath: element count, sort pointers, the two word stores and the
// output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lss_dp
    import lss_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_dp_cmd                  i_cmd,
    output t_dp_stat                 o_stat,
    input  logic signed [WORD_W-1:0] i_push_value,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic signed [WORD_W-1:0] o_read_value,
    output logic [ST_W-1:0]          o_status,
    output logic [OCC_W-1:0]         o_occupancy
);

    logic [CNT_W-1:0]         r_count;
    logic [CNT_W-1:0]         n_count;
    logic [CNT_W-1:0]         r_n;
    logic [CNT_W-1:0]         n_n;
    logic [CNT_W-1:0]         r_t;
    logic [CNT_W-1:0]         n_t;
    logic [CNT_W-1:0]         cnt_m1;
    logic [CNT_W-1:0]         n_m1;
    logic [CNT_W-1:0]         t_m1;
    logic signed [WORD_W-1:0] r_v;
    logic                     r_out_valid;
    logic signed [WORD_W-1:0] r_read_value;
    logic [ST_W-1:0]          r_status;
    logic [OCC_W-1:0]         r_occupancy;

    logic                     e_wr_en;
    logic [ADDR_W-1:0]        e_wr_addr;
    logic [WORD_W-1:0]        e_wr_data;
    logic [ADDR_W-1:0]        e_rd_addr;
    logic [WORD_W-1:0]        e_rd;
    logic [WORD_W-1:0]        s_rd;

    assign cnt_m1 = r_count - CNT_W'(1);
    assign n_m1   = r_n - CNT_W'(1);
    assign t_m1   = r_t - CNT_W'(1);

    always_comb begin
        n_count = r_count;
        if (i_cmd.push_wr) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_cmd.cnt_dec) begin
            n_count = cnt_m1;
        end
    end

    always_comb begin
        n_n = r_n;
        n_t = r_t;
        if (i_cmd.sort_init) begin
            n_n = r_count;
            n_t = '0;
        end else begin
            if (i_cmd.n_dec_rd) begin
                n_n = n_m1;
            end else if (i_cmd.e_wr_s) begin
                n_n = r_n + CNT_W'(1);
            end
            if (i_cmd.t_dec) begin
                n_t = t_m1;
            end else if (i_cmd.s_push) begin
                n_t = r_t + CNT_W'(1);
            end
        end
    end

    // Element store: pushes write at the top, the sort writes at n.
    assign e_wr_en   = i_cmd.push_wr || i_cmd.e_wr_s;
    assign e_wr_addr = i_cmd.push_wr ? r_count[ADDR_W-1:0] : r_n[ADDR_W-1:0];
    assign e_wr_data = i_cmd.push_wr ? i_push_value : s_rd;
    assign e_rd_addr = i_cmd.rd_top ? cnt_m1[ADDR_W-1:0] : n_m1[ADDR_W-1:0];

    lss_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_elem_ram (
        .i_clk     (i_clk),
        .i_wr_en   (e_wr_en),
        .i_wr_addr (e_wr_addr),
        .i_wr_data (e_wr_data),
        .i_rd_addr (e_rd_addr),
        .o_rd_data (e_rd)
    );

    // Scratch store holds the sorted stack while the sort runs.
    lss_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_scratch_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.s_push),
        .i_wr_addr (r_t[ADDR_W-1:0]),
        .i_wr_data (r_v),
        .i_rd_addr (t_m1[ADDR_W-1:0]),
        .o_rd_data (s_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_n <= n_n;
        r_t <= n_t;
        if (i_cmd.load_v) begin
            r_v <= e_rd;
        end
        if (i_cmd.load_out) begin
            r_occupancy <= OCC_W'(n_count);
            case (i_cmd.out_sel)
                OUT_PUSH: begin
                    r_read_value <= '0;
                    r_status     <= STAT_OK;
                end
                OUT_FULL: begin
                    r_read_value <= '0;
                    r_status     <= STAT_FULL;
                end
                OUT_EMPTY: begin
                    r_read_value <= '1;
                    r_status     <= STAT_EMPTY;
                end
                OUT_READ: begin
                    r_read_value <= e_rd;
                    r_status     <= STAT_OK;
                end
                OUT_SORT: begin
                    r_read_value <= WORD_W'(r_count);
                    r_status     <= STAT_OK;
                end
                default: begin
                    r_read_value <= '0;
                    r_status     <= STAT_OK;
                end
            endcase
        end
    end

    assign o_stat.count_zero = (r_count == '0);
    assign o_stat.count_full = (r_count == CNT_W'(DEPTH));
    assign o_stat.n_zero     = (r_n == '0);
    assign o_stat.t_zero     = (r_t == '0);
    assign o_stat.s_gt_v     = ($signed(s_rd) > r_v);
    assign o_stat.out_valid  = r_out_valid;

    assign o_out_valid  = r_out_valid;
    assign o_read_value = r_read_value;
    assign o_status     = r_status;
    assign o_occupancy  = r_occupancy;

    `ASSERT_IMPL(a_no_overwrite, i_clk, i_rst_n, i_cmd.load_out, !(r_out_valid && i_out_stall), "result lost")
    `ASSERT_ALWAYS(a_count_range, i_clk, i_rst_n, r_count <= CNT_W'(DEPTH), "count beyond depth")

endmodule
